FILE: hw/rtl/stcw_pkg.sv
// shared types and constants for the subject tracking crop window unit
package stcw_pkg;

  localparam int FRAC_BITS = 15;
  localparam int DIM_BITS  = 14;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int PROD_W    = DIM_BITS + 16;
  localparam int REM_W     = PROD_W + 1;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [Q_W-1:0] ONE_Q    = Q_W'(1) << FRAC_BITS;
  localparam logic [Q_W-1:0] HALF_Q   = ONE_Q >> 1;
  localparam logic [Q_W-1:0] DEF_Y_Q  = Q_W'((2 * (64'd1 << FRAC_BITS)) / 5);
  localparam logic [Q_W-1:0] THIRD1_Q = Q_W'((64'd1 << FRAC_BITS) / 3);
  localparam logic [Q_W-1:0] THIRD2_Q = Q_W'((2 * (64'd1 << FRAC_BITS)) / 3);

  // divide by 100 through a reciprocal
  localparam int RECIP_SH = 26;
  localparam int RECIP_W  = 20;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << RECIP_SH) + 99) / 100);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO_W  = 3'd0,
    REG_RATIO_H  = 3'd1,
    REG_PREF     = 3'd2,
    REG_THIRDS   = 3'd3,
    REG_PAD      = 3'd4,
    REG_SMOOTH   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_RESET   = 2'd3
  } op_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic sum;
    logic div_step;
    logic thirds;
    logic fin;
  } stcw_cmd_t;

endpackage

FILE: hw/rtl/stcw_ctrl.sv
// sequencing state machine for one compute beat
module stcw_ctrl import stcw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_op,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output stcw_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_DIV, S_THR, S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign fire      = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = fire;
        if (fire && (op_t'(in_op) == OP_COMPUTE)) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_THR;
      end
      S_THR: begin
        cmd.thirds = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/stcw_dp.sv
// datapath: registers, subject tracking, smoothing, divider, thirds and clamp
module stcw_dp import stcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stcw_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            op,
  input  logic [3:0]            subject_kind,
  input  logic [15:0]           confidence,
  input  logic [15:0]           rect_left,
  input  logic [15:0]           rect_top,
  input  logic [15:0]           rect_width,
  input  logic [15:0]           rect_height,
  input  logic [DIM_BITS-1:0]   frame_width,
  input  logic [DIM_BITS-1:0]   frame_height,
  output logic [15:0]           crop_left,
  output logic [15:0]           crop_top,
  output logic [15:0]           crop_width,
  output logic [15:0]           crop_height
);

  logic [15:0] ratio_w_r, ratio_h_r, smooth_f_r;
  logic [3:0]  pref_kind_r;
  logic        thirds_en_r;
  logic [14:0] pad_r;

  logic           pref_found_r, any_r, seeded_r;
  logic [Q_W-1:0] pref_x_r, pref_y_r, best_x_r, best_y_r, sm_x_r, sm_y_r;
  logic [15:0]    best_conf_r;

  logic [Q_W-1:0]      tx_r, ty_r, sb_x_r, sb_y_r;
  logic [DIM_BITS-1:0] fw_r, fh_r;
  logic [31:0]         ps_x_r, ps_y_r;
  logic [32:0]         pt_x_r, pt_y_r;
  logic [PROD_W-1:0]   pa_r, pb_r, den_r;
  logic [REM_W-1:0]    rem_r;
  logic [Q_W-1:0]      quo_r;
  logic                div_first_r, wide_r;
  logic signed [19:0]  ax_r;
  logic [39:0]         py_r;
  logic                py_neg_r;
  logic [15:0]         cl_r, ct_r, cw_r, ch_r;

  // subject centre
  logic [16:0]    cx_sum, cy_sum;
  logic [Q_W-1:0] cx, cy;
  assign cx_sum = {1'b0, rect_left} + {2'b0, rect_width[15:1]};
  assign cy_sum = {1'b0, rect_top} + {2'b0, rect_height[15:1]};
  assign cx = (cx_sum > 17'(ONE_Q)) ? ONE_Q : cx_sum[Q_W-1:0];
  assign cy = (cy_sum > 17'(ONE_Q)) ? ONE_Q : cy_sum[Q_W-1:0];

  logic [15:0] rw, rh;
  assign rw = (ratio_w_r == '0) ? 16'd1 : ratio_w_r;
  assign rh = (ratio_h_r == '0) ? 16'd1 : ratio_h_r;

  // smoothing sum
  logic [16:0] finv;
  logic [33:0] ssum_x, ssum_y;
  logic [17:0] sn_x, sn_y;
  assign finv   = 17'h10000 - {1'b0, smooth_f_r};
  assign ssum_x = {2'b0, ps_x_r} + {1'b0, pt_x_r};
  assign ssum_y = {2'b0, ps_y_r} + {1'b0, pt_y_r};
  assign sn_x   = ssum_x[33:16];
  assign sn_y   = ssum_y[33:16];

  // divider step
  logic [REM_W-1:0] dv_t;
  logic             dv_ge;
  assign dv_t  = div_first_r ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign dv_ge = dv_t >= {1'b0, den_r};

  // thirds pull
  logic signed [19:0] sx_s, sy_s, d1, d2, vx, qx, dy, m15;
  logic [19:0]        my;
  assign sx_s = signed'({4'b0, sm_x_r});
  assign sy_s = signed'({4'b0, sm_y_r});
  assign d1   = sx_s - signed'({4'b0, THIRD1_Q});
  assign d2   = sx_s - signed'({4'b0, THIRD2_Q});
  assign vx   = (((d1 < 0) ? -d1 : d1) < ((d2 < 0) ? -d2 : d2))
              ? signed'({4'b0, THIRD1_Q}) - sx_s : signed'({4'b0, THIRD2_Q}) - sx_s;
  assign qx   = (vx < 0) ? -((-vx) >>> 2) : (vx >>> 2);
  assign dy   = signed'({4'b0, THIRD1_Q}) - sy_s;
  assign m15  = (dy <<< 4) - dy;
  assign my   = (m15 < 0) ? 20'(-m15) : 20'(m15);

  // final position and clamp
  logic [15:0]        cw_v, ch_v;
  logic signed [19:0] qy, ax_f, ay_f, pos_x, pos_y, hi_x, hi_y, mn_x, mn_y, pad_s;
  assign cw_v  = wide_r ? quo_r : ONE_Q;
  assign ch_v  = wide_r ? ONE_Q : quo_r;
  assign qy    = signed'(20'(py_r[39:RECIP_SH]));
  assign ax_f  = thirds_en_r ? ax_r : sx_s;
  assign ay_f  = thirds_en_r ? (py_neg_r ? sy_s - qy : sy_s + qy) : sy_s;
  assign pad_s = signed'({5'b0, pad_r});
  assign pos_x = ax_f - signed'({5'b0, cw_v[15:1]});
  assign pos_y = ay_f - signed'({5'b0, ch_v[15:1]});
  assign hi_x  = signed'({4'b0, ONE_Q}) - signed'({4'b0, cw_v}) - pad_s;
  assign hi_y  = signed'({4'b0, ONE_Q}) - signed'({4'b0, ch_v}) - pad_s;
  assign mn_x  = (pos_x < hi_x) ? pos_x : hi_x;
  assign mn_y  = (pos_y < hi_y) ? pos_y : hi_y;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_w_r   <= 16'd9;
      ratio_h_r   <= 16'd16;
      pref_kind_r <= '0;
      thirds_en_r <= 1'b1;
      pad_r       <= '0;
      smooth_f_r  <= 16'd55705;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RATIO_W: ratio_w_r   <= cfg_data;
        REG_RATIO_H: ratio_h_r   <= cfg_data;
        REG_PREF:    pref_kind_r <= cfg_data[3:0];
        REG_THIRDS:  thirds_en_r <= cfg_data[0];
        REG_PAD:     pad_r       <= cfg_data[14:0];
        REG_SMOOTH:  smooth_f_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pref_found_r <= 1'b0;
      any_r        <= 1'b0;
      seeded_r     <= 1'b0;
      pref_x_r     <= '0;
      pref_y_r     <= '0;
      best_x_r     <= '0;
      best_y_r     <= '0;
      best_conf_r  <= '0;
      sm_x_r       <= HALF_Q;
      sm_y_r       <= DEF_Y_Q;
    end else if (cmd.accept) begin
      case (op_t'(op))
        OP_CLEAR: begin
          pref_found_r <= 1'b0;
          any_r        <= 1'b0;
          best_conf_r  <= '0;
        end
        OP_RESET: begin
          pref_found_r <= 1'b0;
          any_r        <= 1'b0;
          best_conf_r  <= '0;
          seeded_r     <= 1'b0;
          sm_x_r       <= HALF_Q;
          sm_y_r       <= DEF_Y_Q;
        end
        OP_ADD: begin
          if (!pref_found_r && subject_kind == pref_kind_r) begin
            pref_found_r <= 1'b1;
            pref_x_r     <= cx;
            pref_y_r     <= cy;
          end
          if (!any_r || confidence > best_conf_r) begin
            any_r       <= 1'b1;
            best_conf_r <= confidence;
            best_x_r    <= cx;
            best_y_r    <= cy;
          end
        end
        default: ;
      endcase
    end else if (cmd.sum) begin
      seeded_r <= 1'b1;
      sm_x_r   <= (sn_x > 18'(ONE_Q)) ? ONE_Q : sn_x[Q_W-1:0];
      sm_y_r   <= (sn_y > 18'(ONE_Q)) ? ONE_Q : sn_y[Q_W-1:0];
    end
  end

  // compute pipeline
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (pref_found_r) begin
        tx_r <= pref_x_r;
        ty_r <= pref_y_r;
      end else if (any_r) begin
        tx_r <= best_x_r;
        ty_r <= best_y_r;
      end else begin
        tx_r <= HALF_Q;
        ty_r <= DEF_Y_Q;
      end
      sb_x_r <= sm_x_r;
      sb_y_r <= sm_y_r;
      if (frame_height == '0) begin
        fw_r <= DIM_BITS'(1);
        fh_r <= DIM_BITS'(1);
      end else begin
        fw_r <= frame_width;
        fh_r <= frame_height;
      end
    end
    if (cmd.mul) begin
      ps_x_r <= (seeded_r ? sb_x_r : tx_r) * smooth_f_r;
      ps_y_r <= (seeded_r ? sb_y_r : ty_r) * smooth_f_r;
      pt_x_r <= tx_r * finv;
      pt_y_r <= ty_r * finv;
      pa_r   <= fw_r * rh;
      pb_r   <= rw * fh_r;
    end
    if (cmd.sum) begin
      wide_r      <= pa_r >= pb_r;
      rem_r       <= (pa_r >= pb_r) ? {1'b0, pb_r} : {1'b0, pa_r};
      den_r       <= (pa_r >= pb_r) ? pa_r : pb_r;
      quo_r       <= '0;
      div_first_r <= 1'b1;
    end
    if (cmd.div_step) begin
      div_first_r <= 1'b0;
      rem_r       <= dv_ge ? dv_t - {1'b0, den_r} : dv_t;
      quo_r       <= {quo_r[Q_W-2:0], dv_ge};
    end
    if (cmd.thirds) begin
      ax_r     <= sx_s + qx;
      py_r     <= my * RECIP_100;
      py_neg_r <= m15 < 0;
    end
    if (cmd.fin) begin
      cl_r <= (mn_x > pad_s) ? mn_x[15:0] : {1'b0, pad_r};
      ct_r <= (mn_y > pad_s) ? mn_y[15:0] : {1'b0, pad_r};
      cw_r <= cw_v;
      ch_r <= ch_v;
    end
  end

  assign crop_left   = cl_r;
  assign crop_top    = ct_r;
  assign crop_width  = cw_r;
  assign crop_height = ch_r;

endmodule

FILE: hw/rtl/subject_tracking_crop_window_unit.sv
// top level of the subject tracking crop window unit
// Clear, add and reset-tracking beats give no result.
// A compute beat passes from acceptance to the result register through a
// multiply state, a smoothing state, divider states in which a restoring divider
// forms the 16-bit crop size one bit per cycle, a thirds state and a clamp state.
// Input is not accepted while a compute is in flight; a finished result waits
// in the output register while further clear and add beats are taken.
module subject_tracking_crop_window_unit import stcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // subject_kind, confidence, rect_left, rect_top, rect_width, rect_height,
  // frame_width, frame_height
  input  logic [111:0]          in_tdata,
  // op
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // crop_left, crop_top, crop_width, crop_height
  output logic [63:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  stcw_cmd_t cmd;

  stcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  stcw_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (in_tuser),
    .subject_kind (in_tdata[3:0]),
    .confidence   (in_tdata[19:4]),
    .rect_left    (in_tdata[35:20]),
    .rect_top     (in_tdata[51:36]),
    .rect_width   (in_tdata[67:52]),
    .rect_height  (in_tdata[83:68]),
    .frame_width  (in_tdata[97:84]),
    .frame_height (in_tdata[111:98]),
    .crop_left    (out_tdata[15:0]),
    .crop_top     (out_tdata[31:16]),
    .crop_width   (out_tdata[47:32]),
    .crop_height  (out_tdata[63:48])
  );

endmodule

FILE: hw/rtl/stcw_checker.sv
// port-level assertions for the crop window unit and their bind
module stcw_checker import stcw_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] <= ONE_Q && out_tdata[63:48] <= ONE_Q)
    else $error("crop size above one");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] == ONE_Q || out_tdata[63:48] == ONE_Q)
    else $error("crop spans neither full width nor full height");

endmodule

bind subject_tracking_crop_window_unit stcw_checker u_stcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/subject_tracking_crop_window_unit_test.sv
// self-checking testbench for the subject tracking crop window unit
module subject_tracking_crop_window_unit_test;
  import stcw_pkg::*;

  typedef struct {
    op_t         op;
    logic [3:0]  kind;
    logic [15:0] conf;
    logic [15:0] rl;
    logic [15:0] rt;
    logic [15:0] rw;
    logic [15:0] rh;
    logic [13:0] fw;
    logic [13:0] fh;
  } subj_beat_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
  } crop_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [111:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  subj_beat_t pending_beats[$];
  subj_beat_t cur_beat;
  crop_t expected_crops[$];
  int errors = 0;
  bit took = 1'b0;
  bit quiet = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // predictor state
  longint m_ratio_w, m_ratio_h, m_pref, m_thirds, m_pad, m_smooth;
  bit m_pref_found, m_any, m_seeded;
  longint m_pref_x, m_pref_y, m_best_conf, m_best_x, m_best_y, m_sx, m_sy;

  subject_tracking_crop_window_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("subject_tracking_crop_window_unit_test NOT OK");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic void clear_subjects();
    m_pref_found = 0; m_pref_x = 0; m_pref_y = 0;
    m_any = 0; m_best_conf = 0; m_best_x = 0; m_best_y = 0;
  endfunction

  function automatic void reset_tracking();
    clear_subjects();
    m_sx = 16384; m_sy = 13107; m_seeded = 0;
  endfunction

  function automatic longint centre(input logic [15:0] lo, input logic [15:0] len);
    longint c;
    c = longint'(lo) + longint'(len >> 1);
    return c > 32768 ? 32768 : c;
  endfunction

  function automatic longint clamp_edge(input longint pos, input longint size,
                                        input longint pad);
    longint hi, v;
    hi = 32768 - size - pad;
    v = pos < hi ? pos : hi;
    return v > pad ? v : pad;
  endfunction

  function automatic bit crop_step(input subj_beat_t b, output crop_t c);
    longint fw, fh, rw, rh, tx, ty, cw, ch, ax, ay, d1, d2, snap, f;
    c = '{default: '0};
    case (b.op)
      OP_CLEAR: begin
        clear_subjects();
        return 0;
      end
      OP_RESET: begin
        reset_tracking();
        return 0;
      end
      OP_ADD: begin
        tx = centre(b.rl, b.rw);
        ty = centre(b.rt, b.rh);
        if (!m_pref_found && longint'(b.kind) == m_pref) begin
          m_pref_found = 1; m_pref_x = tx; m_pref_y = ty;
        end
        if (!m_any || longint'(b.conf) > m_best_conf) begin
          m_any = 1; m_best_conf = b.conf; m_best_x = tx; m_best_y = ty;
        end
        return 0;
      end
      default: begin
        fw = b.fw; fh = b.fh;
        rw = m_ratio_w ? m_ratio_w : 1;
        rh = m_ratio_h ? m_ratio_h : 1;
        f = m_smooth;
        if (m_pref_found) begin
          tx = m_pref_x; ty = m_pref_y;
        end else if (m_any) begin
          tx = m_best_x; ty = m_best_y;
        end else begin
          tx = 16384; ty = 13107;
        end
        if (!m_seeded) begin
          m_sx = tx; m_sy = ty; m_seeded = 1;
        end
        m_sx = (m_sx * f + tx * (65536 - f)) >>> 16;
        m_sy = (m_sy * f + ty * (65536 - f)) >>> 16;
        if (m_sx > 32768) m_sx = 32768;
        if (m_sy > 32768) m_sy = 32768;
        if (fh == 0) begin
          fw = 1; fh = 1;
        end
        if (fw * rh >= rw * fh) begin
          ch = 32768;
          cw = ((rw * fh) <<< 15) / (rh * fw);
        end else begin
          cw = 32768;
          ch = ((fw * rh) <<< 15) / (fh * rw);
        end
        ax = m_sx; ay = m_sy;
        if (m_thirds != 0) begin
          d1 = ax - 10922; d2 = ax - 21845;
          if (d1 < 0) d1 = -d1;
          if (d2 < 0) d2 = -d2;
          snap = d1 < d2 ? 10922 : 21845;
          ax = m_sx + (snap - m_sx) / 4;
          ay = m_sy + ((10922 - m_sy) * 15) / 100;
        end
        c.left = 16'(clamp_edge(ax - (cw >>> 1), cw, m_pad));
        c.top = 16'(clamp_edge(ay - (ch >>> 1), ch, m_pad));
        c.width = 16'(cw);
        c.height = 16'(ch);
        return 1;
      end
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (in_tvalid && !took) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_beats.size() > 0 && rst_n) begin
      cur_beat = pending_beats.pop_front();
      in_tdata <= {cur_beat.fh, cur_beat.fw, cur_beat.rh, cur_beat.rw, cur_beat.rt,
                   cur_beat.rl, cur_beat.conf, cur_beat.kind};
      in_tuser <= cur_beat.op;
      in_tvalid <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) in_gap <= $urandom_range(1, 3);
    end else begin
      in_tvalid <= 1'b0;
    end
    if (quiet) begin
      out_tready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= $urandom_range(1, 3);
    end
  end

  // monitor
  always @(posedge clk) begin
    subj_beat_t b;
    crop_t want;
    took <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      b.op = op_t'(in_tuser);
      {b.fh, b.fw, b.rh, b.rw, b.rt, b.rl, b.conf, b.kind} = in_tdata;
      if (crop_step(b, want)) expected_crops.push_back(want);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_crops.size() == 0) begin
        report("unexpected beat", out_tdata[15:0], 0);
      end else begin
        want = expected_crops.pop_front();
        if (out_tdata[15:0] != want.left) report("crop_left", out_tdata[15:0], want.left);
        if (out_tdata[31:16] != want.top) report("crop_top", out_tdata[31:16], want.top);
        if (out_tdata[47:32] != want.width)
          report("crop_width", out_tdata[47:32], want.width);
        if (out_tdata[63:48] != want.height)
          report("crop_height", out_tdata[63:48], want.height);
      end
    end
  end

  function automatic subj_beat_t mk(input op_t op, input int kind, input int conf,
                                   input int l, input int t, input int w, input int h,
                                   input int fw, input int fh);
    subj_beat_t b;
    b.op = op; b.kind = 4'(kind); b.conf = 16'(conf);
    b.rl = 16'(l); b.rt = 16'(t); b.rw = 16'(w); b.rh = 16'(h);
    b.fw = 14'(fw); b.fh = 14'(fh);
    return b;
  endfunction

  function automatic int rand_q();
    return $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) * 32768 : $urandom_range(0, 32768);
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 16383;
      2: return $urandom_range(1, 64);
      default: return $urandom_range(0, 16383);
    endcase
  endfunction

  function automatic subj_beat_t rand_beat(input op_t op);
    int kind;
    kind = $urandom_range(0, 2) == 0 ? int'(m_pref) : $urandom_range(0, 15);
    return mk(op, kind, $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(0, 65535),
              rand_q(), rand_q(), rand_q(), rand_q(), rand_dim(), rand_dim());
  endfunction

  task automatic write_regs(input int rw, input int rh, input int pref, input int thirds,
                            input int pad, input int smooth);
    int vals[6];
    vals = '{rw, rh, pref, thirds, pad, smooth};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= 16'(vals[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    m_ratio_w = rw & 16'hFFFF; m_ratio_h = rh & 16'hFFFF; m_pref = pref & 4'hF;
    m_thirds = thirds & 1; m_pad = pad & 15'h7FFF; m_smooth = smooth & 16'hFFFF;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_tvalid || expected_crops.size() > 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic random_phase(input int n_beats);
    int sent;
    int n;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 4) != 0) begin
          pending_beats.push_back(rand_beat(OP_CLEAR));
          sent++;
        end
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) pending_beats.push_back(rand_beat(OP_ADD));
        pending_beats.push_back(rand_beat(OP_COMPUTE));
        sent += n + 1;
      end else begin
        pending_beats.push_back(rand_beat(op_t'($urandom_range(0, 3))));
        sent++;
      end
    end
  endtask

  initial begin
    m_ratio_w = 9; m_ratio_h = 16; m_pref = 0; m_thirds = 1; m_pad = 0; m_smooth = 55705;
    reset_tracking();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    pending_beats.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1920, 1080));
    pending_beats.push_back(mk(OP_ADD, 3, 500, 1000, 2000, 3000, 4000, 0, 0));
    pending_beats.push_back(mk(OP_ADD, 5, 500, 20000, 20000, 100, 100, 0, 0));
    pending_beats.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1080, 1920));
    pending_beats.push_back(mk(OP_ADD, 0, 100, 32768, 32768, 32768, 32768, 0, 0));
    pending_beats.push_back(mk(OP_ADD, 0, 65535, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 16383, 0));
    pending_beats.push_back(mk(OP_CLEAR, 15, 65535, 32768, 32768, 32768, 32768, 16383, 16383));
    pending_beats.push_back(mk(OP_ADD, 9, 65535, 32768, 0, 32768, 0, 0, 0));
    pending_beats.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 500));
    pending_beats.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 16383, 16383));
    pending_beats.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1, 16383));
    pending_beats.push_back(mk(OP_RESET, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 640, 480));
    drain();

    random_phase(220);
    drain();
    write_regs(1, 65535, 15, 0, 16384, 0);
    random_phase(220);
    drain();
    write_regs(65535, 1, 7, 1, 16384, 65535);
    random_phase(220);
    drain();
    write_regs(0, 0, 0, 1, 3000, 32768);
    random_phase(220);
    drain();
    write_regs(16, 9, 4, 0, 0, 65535);
    random_phase(220);
    drain();
    write_regs(4, 3, 2, 1, 1000, 0);
    random_phase(220);
    drain();
    write_regs(9, 16, 0, 1, 0, 55705);
    random_phase(200);
    drain();
    quiet = 1'b1;
    write_regs(21, 9, 1, 1, 500, 40000);
    random_phase(270);
    drain();

    if (errors == 0) begin
      $display("subject_tracking_crop_window_unit_test OK");
    end else begin
      $display("subject_tracking_crop_window_unit_test NOT OK");
    end
    $finish;
  end

endmodule
